@@ rtl/wsfr_pkg.sv @@
// Shared types and constants for the WebSocket frame receiver.
`timescale 1ns / 1ps

package wsfr_pkg;

    // Width kept for the frame length counter
    localparam int LEN_BITS = 64;

    // Parse phases
    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_EXT16 = 3'd2;
    localparam logic [2:0] PH_EXT64 = 3'd3;
    localparam logic [2:0] PH_KEY   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_TEXT    = 3'd1;
    localparam logic [2:0] KIND_BINARY  = 3'd2;
    localparam logic [2:0] KIND_CLOSE   = 3'd3;
    localparam logic [2:0] KIND_PING    = 3'd4;
    localparam logic [2:0] KIND_PONG    = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;
    localparam logic [2:0] KIND_DROPPED = 3'd7;

    // Frame opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Header length codes
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Register byte addresses
    localparam logic [2:0] ADDR_MAX_MSG = 3'd0;
    localparam logic [15:0] MAX_MSG_RESET = 16'd1024;

    // Result queue depth
    localparam int QDEPTH = 4;

    typedef logic [LEN_BITS-1:0] t_len;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_offset;
        logic [15:0] message_length;
        logic [3:0]  raw_opcode;
        logic        is_last;
    } t_result;

    // Completion kind for a message opcode
    function automatic logic [2:0] op_to_kind(input logic [3:0] op);
        logic [2:0] k;
        case (op)
            OP_TEXT:   k = KIND_TEXT;
            OP_BINARY: k = KIND_BINARY;
            OP_CLOSE:  k = KIND_CLOSE;
            OP_PING:   k = KIND_PING;
            OP_PONG:   k = KIND_PONG;
            default:   k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/websocket_frame_receiver_unit.sv @@
// Top level of the WebSocket frame receiver: byte parser, result queue, register port.
`timescale 1ns / 1ps

// Usage:
//  s_* stream: one received byte per word (s_tdata). The parser walks the
//  header, extended length, mask key and payload, one byte per cycle while s_tready is high.
//  m_* stream: result words. m_tuser carries the kind, m_tlast marks the last
//  result caused by one input byte; m_tdata holds data byte, offset, length
//  and opcode. A byte gives zero, one or two results.
//  APB port: max_message_bytes at byte address 0 (reset 1024), to be written only
//  while the block is idle; the user is bound by this, the block does not enforce it.
//  Latency: results are pushed into a 4-word queue at the accept edge and show
//  on m_tvalid the next cycle. Throughput: one byte per cycle; s_tready is
//  high while at least two queue words are free, so a stalled receiver
//  back-pressures the byte stream once three or four results are waiting.
//  Reset (synchronous, active low) returns the parser to the first header byte,
//  empties the queue and restores the length limit.
module websocket_frame_receiver_unit
    import wsfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] data_byte, [23:8] byte_offset,
                                   // [39:24] message_length, [43:40] raw_opcode
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,   // is_last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // parser state
    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_fcount, n_fcount;
    logic        r_final, n_final;
    logic        r_masked, n_masked;
    logic [3:0]  r_opcode, n_opcode;
    t_len        r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [16:0] r_acc, n_acc;
    logic        r_frag, n_frag;
    logic        r_drop, n_drop;
    logic [15:0] r_max;

    // result queue
    t_result     r_q [QDEPTH];
    logic [1:0]  r_wr, r_rd;
    logic [2:0]  r_count, n_count;

    t_result     res_a, res_b, res_tmp;
    logic [1:0]  cnt;
    logic        do_known, do_begin, do_end, drop_now;
    logic [16:0] room;
    logic [63:0] rem_w;
    logic [17:0] total;
    logic [7:0]  b;
    logic        in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign b       = s_tdata;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_MSG) ? {16'd0, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_MSG_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_MSG) begin
            r_max <= pwdata[15:0];
        end
    end

    // per-byte parse step
    always_comb begin
        n_phase  = r_phase;
        n_fcount = r_fcount;
        n_final  = r_final;
        n_masked = r_masked;
        n_opcode = r_opcode;
        n_rem    = r_rem;
        n_key    = r_key;
        n_acc    = r_acc;
        n_frag   = r_frag;
        n_drop   = r_drop;
        res_a    = '0;
        res_b    = '0;
        res_tmp  = '0;
        cnt      = 2'd0;
        do_known = 1'b0;
        do_begin = 1'b0;
        do_end   = 1'b0;
        drop_now = 1'b0;
        room     = '0;
        rem_w    = '0;
        total    = '0;

        case (r_phase)
            PH_HDR1: begin
                n_masked = b[7];
                n_fcount = 4'd0;
                n_rem    = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    n_phase = PH_EXT16;
                end else if (b[6:0] == LEN7_EXT64) begin
                    n_phase = PH_EXT64;
                end else begin
                    n_rem    = LEN_BITS'(b[6:0]);
                    do_known = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64: begin
                n_rem    = LEN_BITS'({r_rem, b});
                n_fcount = r_fcount + 4'd1;
                if (n_fcount >= ((r_phase == PH_EXT16) ? 4'd2 : 4'd8)) begin
                    do_known = 1'b1;
                end
            end
            PH_KEY: begin
                n_key    = {r_key[23:0], b};
                n_fcount = r_fcount + 4'd1;
                if (n_fcount >= 4'd4) begin
                    do_begin = 1'b1;
                end
            end
            PH_DATA: begin
                if (!r_drop) begin
                    res_a.kind        = KIND_PAYLOAD;
                    res_a.data_byte   = b ^ (r_masked ? r_key[31:24] : 8'd0);
                    res_a.byte_offset = r_acc[15:0];
                    res_a.raw_opcode  = r_opcode;
                    n_key             = {r_key[23:0], r_key[31:24]};
                    n_acc             = r_acc + 17'd1;
                    cnt               = 2'd1;
                end
                n_rem = r_rem - LEN_BITS'(1);
                if (n_rem == '0) begin
                    do_end = 1'b1;
                end
            end
            default: begin
                // first header byte
                n_final = b[7];
                if (!r_frag) begin
                    n_opcode = b[3:0];
                end
                n_phase = PH_HDR1;
            end
        endcase

        // length complete: key next or payload
        if (do_known) begin
            if (n_masked) begin
                n_phase  = PH_KEY;
                n_fcount = 4'd0;
            end else begin
                do_begin = 1'b1;
            end
        end

        // limit check at payload start
        if (do_begin) begin
            room     = {1'b0, r_max} - r_acc;
            rem_w    = 64'(n_rem);
            drop_now = room[16] || (rem_w > {48'd0, room[15:0]});
            if (drop_now) begin
                total = (rem_w[63:17] != '0) ? 18'h0FFFF : ({1'b0, r_acc} + rem_w[17:0]);
                res_a.kind           = KIND_DROPPED;
                res_a.message_length = (total > 18'h0FFFF) ? 16'hFFFF : total[15:0];
                res_a.raw_opcode     = r_opcode;
                cnt    = 2'd1;
                n_acc  = '0;
                n_frag = 1'b0;
                n_drop = (n_rem != '0);
                n_phase = (n_rem == '0) ? PH_HDR0 : PH_DATA;
            end else if (n_rem == '0) begin
                do_end = 1'b1;
            end else begin
                n_phase = PH_DATA;
            end
        end

        // end of frame
        if (do_end) begin
            n_phase = PH_HDR0;
            if (n_drop) begin
                n_drop = 1'b0;
            end else if (!r_final) begin
                n_frag = 1'b1;
            end else begin
                res_tmp.kind           = op_to_kind(r_opcode);
                res_tmp.message_length = n_acc[15:0];
                res_tmp.raw_opcode     = r_opcode;
                if (cnt == 2'd0) begin
                    res_a = res_tmp;
                end else begin
                    res_b = res_tmp;
                end
                cnt    = cnt + 2'd1;
                n_acc  = '0;
                n_frag = 1'b0;
            end
        end

        // mark the last result of this byte
        if (cnt == 2'd1) begin
            res_a.is_last = 1'b1;
        end else if (cnt == 2'd2) begin
            res_b.is_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_fcount <= '0;
            r_final  <= 1'b0;
            r_masked <= 1'b0;
            r_opcode <= '0;
            r_rem    <= '0;
            r_key    <= '0;
            r_acc    <= '0;
            r_frag   <= 1'b0;
            r_drop   <= 1'b0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_fcount <= n_fcount;
            r_final  <= n_final;
            r_masked <= n_masked;
            r_opcode <= n_opcode;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_acc    <= n_acc;
            r_frag   <= n_frag;
            r_drop   <= n_drop;
        end
    end

    // result queue: up to two pushes, one pop per cycle
    assign s_tready = (r_count <= 3'(QDEPTH - 2));
    assign n_count  = r_count + (in_acc ? {1'b0, cnt} : 3'd0) - {2'd0, out_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (in_acc) begin
                r_wr <= r_wr + cnt;
            end
            if (out_acc) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && cnt != 2'd0) begin
            r_q[r_wr] <= res_a;
        end
        if (in_acc && cnt == 2'd2) begin
            r_q[r_wr + 2'd1] <= res_b;
        end
    end

    // output word
    assign m_tvalid = (r_count != 3'd0);
    assign m_tuser  = r_q[r_rd].kind;
    assign m_tlast  = r_q[r_rd].is_last;
    assign m_tdata  = {4'd0, r_q[r_rd].raw_opcode, r_q[r_rd].message_length,
                       r_q[r_rd].byte_offset, r_q[r_rd].data_byte};

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(QDEPTH))
        else $error("result queue overflow");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> (r_count <= 3'(QDEPTH - 2)))
        else $error("byte accepted without room for two results");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid == (r_count != 3'd0))
        else $error("output valid does not match queue fill");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == KIND_PAYLOAD) |-> (m_tdata[39:24] == 16'd0))
        else $error("payload word with nonzero message length");

    a_event_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != KIND_PAYLOAD) |-> (m_tdata[23:0] == 24'd0 && m_tlast))
        else $error("event word with data or offset, or not last");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the WebSocket frame receiver: random framed byte traffic.
`timescale 1ns / 1ps

module testbench
    import wsfr_pkg::*;
();

    // Length field encodings used by the frame builder
    localparam int LEN_SHORT = 0;
    localparam int LEN_EXT16 = 1;
    localparam int LEN_EXT64 = 2;

    // Cycles without any accepted word before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Cycles allowed for the block to settle after the last expected word
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [7:0] data_byte, [23:8] byte_offset,
                                    // [39:24] message_length, [43:40] raw_opcode
    logic [2:0]  m_tuser;           // [2:0] kind
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    websocket_frame_receiver_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Byte stream still to be sent, and result words still to arrive
    logic [7:0] tx_stream[$];
    t_result    results_due[$];
    int         queued = 0;
    int         errors = 0;
    int         stall_cycles = 0;
    int         snd_idle = 0;
    int         rcv_idle = 0;
    bit         took = 1'b0;

    // Deframer state mirrored by the predictor
    logic [15:0] lim = MAX_MSG_RESET;
    logic [2:0]  ph = PH_HDR0;
    logic [3:0]  fcnt = '0;
    logic        fin = 1'b0;
    logic        msk = 1'b0;
    logic [3:0]  mop = '0;
    logic [63:0] remain = '0;
    logic [31:0] key = '0;
    logic [16:0] acc = '0;
    logic        frag_open = 1'b0;
    logic        skipping = 1'b0;

    // Words produced by the byte being predicted
    t_result     step_res[2];
    int          step_n;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    task automatic note(input logic [2:0] k, input logic [7:0] data,
                        input logic [15:0] offs, input logic [15:0] len);
        step_res[step_n].kind           = k;
        step_res[step_n].data_byte      = data;
        step_res[step_n].byte_offset    = offs;
        step_res[step_n].message_length = len;
        step_res[step_n].raw_opcode     = mop;
        step_res[step_n].is_last        = 1'b0;
        step_n++;
    endtask

    // End of a frame: a final frame completes the message
    task automatic close_frame();
        logic [2:0] k;
        ph = PH_HDR0;
        if (skipping) begin
            skipping = 1'b0;
        end else if (!fin) begin
            frag_open = 1'b1;
        end else begin
            case (mop)
                OP_TEXT:   k = KIND_TEXT;
                OP_BINARY: k = KIND_BINARY;
                OP_CLOSE:  k = KIND_CLOSE;
                OP_PING:   k = KIND_PING;
                OP_PONG:   k = KIND_PONG;
                default:   k = KIND_UNKNOWN;
            endcase
            note(k, 8'h00, 16'h0000, acc[15:0]);
            acc = '0;
            frag_open = 1'b0;
        end
    endtask

    // Length and key known: accept or drop the frame against the limit
    task automatic start_payload();
        bit over;
        logic [63:0] total;
        over = (acc > {1'b0, lim});
        if (!over)
            over = (remain > ({48'd0, lim} - {47'd0, acc}));
        if (over) begin
            if (remain >= 64'h20000)
                total = 64'hFFFF;
            else
                total = {47'd0, acc} + remain;
            if (total > 64'hFFFF)
                total = 64'hFFFF;
            note(KIND_DROPPED, 8'h00, 16'h0000, total[15:0]);
            acc = '0;
            frag_open = 1'b0;
            skipping = 1'b1;
            if (remain == 64'd0) begin
                skipping = 1'b0;
                ph = PH_HDR0;
            end else begin
                ph = PH_DATA;
            end
        end else if (remain == 64'd0) begin
            close_frame();
        end else begin
            ph = PH_DATA;
        end
    endtask

    task automatic after_length();
        if (msk) begin
            ph = PH_KEY;
            fcnt = '0;
        end else begin
            start_payload();
        end
    endtask

    // One accepted byte: advance the parser, queue the words it causes
    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] k;
        step_n = 0;
        case (ph)
            PH_HDR1: begin
                msk = b[7];
                fcnt = '0;
                remain = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    ph = PH_EXT16;
                end else if (b[6:0] == LEN7_EXT64) begin
                    ph = PH_EXT64;
                end else begin
                    remain = {57'd0, b[6:0]};
                    after_length();
                end
            end
            PH_EXT16, PH_EXT64: begin
                remain = {remain[55:0], b};
                fcnt = fcnt + 4'd1;
                if (fcnt >= ((ph == PH_EXT16) ? 4'd2 : 4'd8))
                    after_length();
            end
            PH_KEY: begin
                key = {key[23:0], b};
                fcnt = fcnt + 4'd1;
                if (fcnt >= 4'd4)
                    start_payload();
            end
            PH_DATA: begin
                if (!skipping) begin
                    k = msk ? key[31:24] : 8'h00;
                    key = {key[23:0], key[31:24]};
                    note(KIND_PAYLOAD, b ^ k, acc[15:0], 16'h0000);
                    acc = acc + 17'd1;
                end
                remain = remain - 64'd1;
                if (remain == 64'd0)
                    close_frame();
            end
            default: begin
                fin = b[7];
                if (!frag_open)
                    mop = b[3:0];
                ph = PH_HDR1;
            end
        endcase
        if (step_n > 0)
            step_res[step_n - 1].is_last = 1'b1;
        for (int i = 0; i < step_n; i++)
            results_due.push_back(step_res[i]);
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    function automatic int mismatch(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_result();
        t_result want;
        if (results_due.size() == 0) begin
            $error("result word with none expected: kind %0d", m_tuser);
            errors++;
        end else begin
            want = results_due.pop_front();
            errors += mismatch("kind", 16'(want.kind), 16'(m_tuser));
            errors += mismatch("data_byte", 16'(want.data_byte), 16'(m_tdata[7:0]));
            errors += mismatch("byte_offset", want.byte_offset, m_tdata[23:8]);
            errors += mismatch("message_length", want.message_length, m_tdata[39:24]);
            errors += mismatch("raw_opcode", 16'(want.raw_opcode), 16'(m_tdata[43:40]));
            errors += mismatch("is_last", 16'(want.is_last), 16'(m_tlast));
        end
    endtask

    // Monitor: sample both streams at the rising edge, watchdog on progress
    always @(posedge i_clk) begin
        took = 1'b0;
        if (i_rst_n) begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                void'(tx_stream.pop_front());
                took = 1'b1;
            end
            if (took || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Driver: byte stream and result back-pressure change at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // a word offered and not yet taken stays on the bus
            if (!(s_tvalid && !took)) begin
                if (tx_stream.size() != 0 && $urandom_range(99) >= snd_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_stream[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Register write with readback
    task automatic set_limit(input logic [15:0] value);
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_MSG;
        pwdata  <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        errors += mismatch("max_message_bytes", value, got[15:0]);
        lim = value;
    endtask

    // Wait until every word has gone through and the block has settled
    task automatic drain();
        while (tx_stream.size() != 0 || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_key();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'hFFFF_FFFF;
        if (r == 1)
            return 32'h0000_0000;
        return $urandom;
    endfunction

    // Mostly short payloads, a few that need the 16-bit length
    function automatic logic [63:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 64'd0;
        if (r < 80)
            return 64'($urandom_range(1, 8));
        if (r < 97)
            return 64'($urandom_range(9, 40));
        return 64'($urandom_range(126, 300));
    endfunction

    // One frame: header, length field, optional key, body bytes
    task automatic add_frame(input bit f, input logic [3:0] op, input bit masked,
                             input logic [63:0] len, input int enc,
                             input logic [31:0] k, input int body);
        int start_n;
        start_n = tx_stream.size();
        tx_stream.push_back({f, 3'($urandom_range(7)), op});
        case (enc)
            LEN_EXT16: begin
                tx_stream.push_back({masked, LEN7_EXT16});
                tx_stream.push_back(len[15:8]);
                tx_stream.push_back(len[7:0]);
            end
            LEN_EXT64: begin
                tx_stream.push_back({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    tx_stream.push_back(len[8*i +: 8]);
            end
            default: begin
                tx_stream.push_back({masked, len[6:0]});
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                tx_stream.push_back(k[8*i +: 8]);
        for (int i = 0; i < body; i++)
            tx_stream.push_back(8'($urandom_range(255)));
        queued += tx_stream.size() - start_n;
    endtask

    // Random messages of one to three fragments, plus junk frames
    task automatic gen_traffic(input int budget);
        int stop_at;
        int nfrag;
        int r;
        int enc;
        logic [3:0] op;
        logic [3:0] opc;
        logic [63:0] len;
        stop_at = queued + budget;
        while (queued < stop_at) begin
            if ($urandom_range(99) < 80) begin
                case ($urandom_range(7))
                    0: op = OP_TEXT;
                    1: op = OP_BINARY;
                    2: op = OP_CLOSE;
                    3: op = OP_PING;
                    4: op = OP_PONG;
                    5: op = 4'h0;
                    6: op = 4'($urandom_range(15));
                    default: op = OP_TEXT;
                endcase
                nfrag = $urandom_range(1, 3);
                for (int i = 0; i < nfrag; i++) begin
                    // continuations, now and then a control opcode in the middle
                    opc = (i == 0) ? op : (($urandom_range(4) == 0) ? OP_PING : 4'h0);
                    len = pick_len();
                    if (len >= 64'd126) begin
                        enc = LEN_EXT16;
                    end else begin
                        r = $urandom_range(9);
                        enc = (r < 7) ? LEN_SHORT : ((r < 9) ? LEN_EXT16 : LEN_EXT64);
                    end
                    add_frame(i == nfrag - 1, opc, $urandom_range(9) < 7, len, enc,
                              rand_key(), int'(len));
                end
            end else begin
                len = 64'($urandom_range(125));
                add_frame(1'($urandom_range(1)), 4'($urandom_range(15)),
                          1'($urandom_range(1)), len, LEN_SHORT, rand_key(), int'(len));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset limit, sender idles lightly, receiver heavily
        snd_idle = 12;
        rcv_idle = 74;
        // text fragment with 64-bit length, then a ping inside it that closes it
        add_frame(1'b0, OP_TEXT, 1'b0, 64'd1, LEN_EXT64, 32'h0, 1);
        add_frame(1'b1, OP_PING, 1'b0, 64'd0, LEN_SHORT, 32'h0, 0);
        // opcode zero opening a message, masked with an all-ones key
        add_frame(1'b1, 4'h0, 1'b1, 64'd1, LEN_SHORT, 32'hFFFF_FFFF, 1);
        // binary fragment left open across the limit change
        add_frame(1'b0, OP_BINARY, 1'b0, 64'd1, LEN_EXT16, 32'h0, 1);
        drain();

        // Limit zero, below the open fragment: next frame is dropped
        set_limit(16'd0);
        add_frame(1'b1, 4'h0, 1'b0, 64'd0, LEN_SHORT, 32'h0, 0);
        gen_traffic(65);
        drain();

        snd_idle = 74;
        rcv_idle = 12;
        set_limit(16'd48);
        gen_traffic(105);
        drain();
        set_limit(16'hFFFF);
        gen_traffic(105);
        drain();

        // No idling; finish with a huge 64-bit length that is dropped
        snd_idle = 0;
        rcv_idle = 0;
        set_limit(16'($urandom_range(20, 300)));
        gen_traffic(90);
        add_frame(1'b1, OP_BINARY, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, LEN_EXT64,
                  rand_key(), 6);
        drain();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/wsfr_pkg.sv
rtl/websocket_frame_receiver_unit.sv
verif/testbench.sv
